FILE: sv/mrc_pkg.sv
// Package for the Modbus RTU frame/CRC engine: result item types, kind and
// status codes, and the byte-wide CRC-16 update. No dependencies.
package mrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_RX     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ADDR  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_SHORT    = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       eor;
  } item_t;

  // Up to four result items from one input item, packed from index 0.
  typedef struct packed {
    logic [2:0]       cnt;
    item_t [3:0]      items;
  } bundle_t;

  // CRC-16 (reflected poly 0xA001), one byte folded in, LSB first.
  function automatic logic [15:0] crc8(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic item_t mk_item(input kind_t kind, input logic [7:0] data,
                                    input status_t status, input logic eor);
    item_t it;
    it.kind   = kind;
    it.data   = data;
    it.status = status;
    it.eor    = eor;
    return it;
  endfunction

endpackage

FILE: sv/modbus_rtu_frame_crc.sv
// Modbus RTU frame engine with CRC-16: top level with input register, slave
// address register, frame step and result register. Uses mrc_pkg.
// An item passes through the input register and then the result register,
// where its first result becomes valid. Throughput: one input item per cycle
// while each item yields at most one result and out_ready is high; an item
// yielding n results (up to 4) holds the result port until all n are taken.
// Reset (rst_n, synchronous, active low): frame state, CRCs, slave address and
// all valid flags cleared; no clearing pass, in_ready low during reset and
// high from the first cycle after it.
module modbus_rtu_frame_crc (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: slave address, written with no wait
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_end_of_run
);

  // Slave address plus its CRC contribution, precomputed at write time so
  // the frame-open path runs only one byte of CRC.
  logic [7:0]  slave_addr_r;
  logic [15:0] addr_crc_r;

  // Input register: one item waiting for the frame step.
  logic        in_v_r;
  logic        mode_r;
  logic [7:0]  data_r;
  logic        last_r;

  logic              q_free;
  logic              step_fire;
  mrc_pkg::bundle_t  bundle;
  mrc_pkg::item_t    head;

  // The item in the input register moves on once the result register is
  // empty or hands out its final item in this cycle.
  assign step_fire = in_v_r && q_free;
  assign in_ready  = rst_n && (!in_v_r || q_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'h00;
      addr_crc_r   <= mrc_pkg::crc8(mrc_pkg::CRC_INIT, 8'h00);
      in_v_r       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        slave_addr_r <= cfg_write_data;
        addr_crc_r   <= mrc_pkg::crc8(mrc_pkg::CRC_INIT, cfg_write_data);
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
    end
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  mrc_frame_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (step_fire),
    .mode       (mode_r),
    .data_byte  (data_r),
    .last_byte  (last_r),
    .slave_addr (slave_addr_r),
    .addr_crc   (addr_crc_r),
    .bundle     (bundle)
  );

  mrc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_fire),
    .bundle    (bundle),
    .free      (q_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_byte       = head.data;
  assign out_status     = head.status;
  assign out_end_of_run = head.eor;

`ifndef SYNTHESIS
  // Status items close a frame and carry no byte.
  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == mrc_pkg::KIND_STATUS))
      |-> (out_end_of_run && (out_byte == 8'h00)))
    else $error("status item without end_of_run or with nonzero byte");

  // Byte items always report ok status.
  a_byte_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != mrc_pkg::KIND_STATUS)) |-> (out_status == mrc_pkg::ST_OK))
    else $error("byte item with nonzero status");

  // A received payload byte never ends a frame.
  a_rx_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == mrc_pkg::KIND_RX)) |-> !out_end_of_run)
    else $error("received payload byte flagged as end of frame");

  // A held result that is not taken stays put for the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_kind)))
    else $error("result changed while stalled");
`endif

endmodule

FILE: sv/mrc_frame_step.sv
// Frame step for the Modbus RTU engine: transmit and receive frame state and
// the combinational framing/CRC logic that builds a result bundle. Uses mrc_pkg.
module mrc_frame_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 mode,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [7:0]           slave_addr,
  input  logic [15:0]          addr_crc,
  output mrc_pkg::bundle_t     bundle
);

  logic [15:0] tx_crc_r, tx_crc_nxt;
  logic        tx_in_frame_r, tx_in_frame_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [1:0]  rx_cnt_r, rx_cnt_nxt;
  logic [7:0]  rx_h0_r, rx_h0_nxt;
  logic [7:0]  rx_h1_r, rx_h1_nxt;

  logic [15:0] crc_base;
  logic [15:0] crc_b;
  logic [2:0]  k;

  always_comb begin
    tx_crc_nxt      = tx_crc_r;
    tx_in_frame_nxt = tx_in_frame_r;
    rx_crc_nxt      = rx_crc_r;
    rx_cnt_nxt      = rx_cnt_r;
    rx_h0_nxt       = rx_h0_r;
    rx_h1_nxt       = rx_h1_r;
    bundle          = '0;
    k               = 3'd0;
    crc_base        = tx_in_frame_r ? tx_crc_r : addr_crc;
    crc_b           = mrc_pkg::crc8(crc_base, data_byte);

    if (!mode) begin
      if (!tx_in_frame_r && (slave_addr == 8'h00)) begin
        // no address: byte dropped, status only on a last byte
        if (last_byte) begin
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_STATUS, 8'h00,
                                                  mrc_pkg::ST_NO_ADDR, 1'b1);
          k = k + 3'd1;
        end
      end else begin
        if (!tx_in_frame_r) begin
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_TX, slave_addr,
                                                  mrc_pkg::ST_OK, 1'b0);
          k = k + 3'd1;
        end
        bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_TX, data_byte,
                                                mrc_pkg::ST_OK, 1'b0);
        k = k + 3'd1;
        if (last_byte) begin
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_TX, crc_b[7:0],
                                                  mrc_pkg::ST_OK, 1'b0);
          k = k + 3'd1;
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_TX, crc_b[15:8],
                                                  mrc_pkg::ST_OK, 1'b1);
          k = k + 3'd1;
          tx_crc_nxt      = mrc_pkg::CRC_INIT;
          tx_in_frame_nxt = 1'b0;
        end else begin
          tx_crc_nxt      = crc_b;
          tx_in_frame_nxt = 1'b1;
        end
      end
    end else begin
      unique case (rx_cnt_r)
        2'd0: begin
          rx_crc_nxt = mrc_pkg::crc8(mrc_pkg::CRC_INIT, data_byte);
          rx_cnt_nxt = 2'd1;
        end
        2'd1: begin
          rx_h0_nxt  = data_byte;
          rx_cnt_nxt = 2'd2;
        end
        2'd2: begin
          rx_h1_nxt  = data_byte;
          rx_cnt_nxt = 2'd3;
        end
        default: begin
          // oldest held byte is payload: fold it in and forward it
          rx_crc_nxt = mrc_pkg::crc8(rx_crc_r, rx_h0_r);
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_RX, rx_h0_r,
                                                  mrc_pkg::ST_OK, 1'b0);
          k = k + 3'd1;
          rx_h0_nxt = rx_h1_r;
          rx_h1_nxt = data_byte;
        end
      endcase

      if (last_byte) begin
        if (rx_cnt_nxt != 2'd3) begin
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_STATUS, 8'h00,
                                                  mrc_pkg::ST_SHORT, 1'b1);
        end else if ({rx_h1_nxt, rx_h0_nxt} == rx_crc_nxt) begin
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_STATUS, 8'h00,
                                                  mrc_pkg::ST_OK, 1'b1);
        end else begin
          bundle.items[k[1:0]] = mrc_pkg::mk_item(mrc_pkg::KIND_STATUS, 8'h00,
                                                  mrc_pkg::ST_MISMATCH, 1'b1);
        end
        k = k + 3'd1;
        rx_crc_nxt = mrc_pkg::CRC_INIT;
        rx_cnt_nxt = 2'd0;
        rx_h0_nxt  = 8'h00;
        rx_h1_nxt  = 8'h00;
      end
    end
    bundle.cnt = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_crc_r      <= mrc_pkg::CRC_INIT;
      tx_in_frame_r <= 1'b0;
      rx_crc_r      <= mrc_pkg::CRC_INIT;
      rx_cnt_r      <= 2'd0;
      rx_h0_r       <= 8'h00;
      rx_h1_r       <= 8'h00;
    end else if (fire) begin
      tx_crc_r      <= tx_crc_nxt;
      tx_in_frame_r <= tx_in_frame_nxt;
      rx_crc_r      <= rx_crc_nxt;
      rx_cnt_r      <= rx_cnt_nxt;
      rx_h0_r       <= rx_h0_nxt;
      rx_h1_r       <= rx_h1_nxt;
    end
  end

endmodule

FILE: sv/mrc_out_queue.sv
// Result register for the Modbus RTU engine: holds one bundle of up to four
// result items and hands them out one per transfer. Uses mrc_pkg.
module mrc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mrc_pkg::bundle_t  bundle,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output mrc_pkg::item_t    head
);

  logic [2:0]             cnt_r, cnt_nxt;
  mrc_pkg::item_t [3:0]   items_r, items_nxt;
  logic                   take;

  assign take      = (cnt_r != 3'd0) && out_ready;
  assign free      = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign out_valid = (cnt_r != 3'd0);
  assign head      = items_r[0];

  always_comb begin
    cnt_nxt   = cnt_r;
    items_nxt = items_r;
    if (load) begin
      cnt_nxt   = bundle.cnt;
      items_nxt = bundle.items;
    end else if (take) begin
      cnt_nxt = cnt_r - 3'd1;
      for (int i = 0; i < 3; i++) begin
        items_nxt[i] = items_r[i+1];
      end
      items_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    items_r <= items_nxt;
  end

endmodule

FILE: bench/tb_modbus_rtu_frame_crc.sv
// Testbench for modbus_rtu_frame_crc: drives request and response bytes,
// predicts framing and CRC-16 results in a scoreboard class and checks them.
// Depends on mrc_pkg for the result codes and the CRC constants.
module tb_modbus_rtu_frame_crc;

  // One input transfer as the bench sees it.
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } stim_t;

  localparam int unsigned ITEM_TARGET = 500;
  localparam int unsigned HOLD_CYCLES = 300; // long receiver hold-off
  localparam int unsigned SETTLE      = 8;   // covers the input and result registers
  localparam int unsigned MAX_PRINTS  = 40;

  // Frame predictor plus store of expected result items.
  class frame_scoreboard;
    mrc_pkg::item_t expected_q[$];
    int unsigned errors;
    logic [7:0]  slave_addr;
    logic [15:0] tx_crc;
    bit          tx_open;
    logic [15:0] rx_crc;
    int unsigned rx_seen;    // bytes of the response so far, stops at 3
    logic [7:0]  rx_hold[2]; // last two bytes, possibly the CRC

    function new();
      errors     = 0;
      slave_addr = 8'h00;
      tx_crc     = mrc_pkg::CRC_INIT;
      tx_open    = 1'b0;
      rx_crc     = mrc_pkg::CRC_INIT;
      rx_seen    = 0;
      rx_hold[0] = 8'h00;
      rx_hold[1] = 8'h00;
    endfunction

    // Bit-serial CRC-16, data LSB first.
    static function logic [15:0] fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = {1'b0, c[15:1]};
        if (fb) begin
          c = c ^ mrc_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_address(logic [7:0] a);
      slave_addr = a;
    endfunction

    function void push(mrc_pkg::kind_t k, logic [7:0] d, mrc_pkg::status_t s, logic e);
      mrc_pkg::item_t it;
      it.kind   = k;
      it.data   = d;
      it.status = s;
      it.eor    = e;
      expected_q.push_back(it);
    endfunction

    // Returns 1 when the block is expected to ignore the byte outright.
    function bit note_input(logic mode, logic [7:0] b, logic last);
      mrc_pkg::status_t st;
      if (!mode) begin
        if (!tx_open) begin
          if (slave_addr == 8'h00) begin
            if (last) begin
              push(mrc_pkg::KIND_STATUS, 8'h00, mrc_pkg::ST_NO_ADDR, 1'b1);
            end
            return !last;
          end
          tx_crc  = fold(mrc_pkg::CRC_INIT, slave_addr);
          tx_open = 1'b1;
          push(mrc_pkg::KIND_TX, slave_addr, mrc_pkg::ST_OK, 1'b0);
        end
        tx_crc = fold(tx_crc, b);
        push(mrc_pkg::KIND_TX, b, mrc_pkg::ST_OK, 1'b0);
        if (last) begin
          push(mrc_pkg::KIND_TX, tx_crc[7:0], mrc_pkg::ST_OK, 1'b0);
          push(mrc_pkg::KIND_TX, tx_crc[15:8], mrc_pkg::ST_OK, 1'b1);
          tx_crc  = mrc_pkg::CRC_INIT;
          tx_open = 1'b0;
        end
        return 1'b0;
      end
      if (rx_seen == 0) begin
        rx_crc  = fold(mrc_pkg::CRC_INIT, b);
        rx_seen = 1;
      end else if (rx_seen >= 3) begin
        rx_crc = fold(rx_crc, rx_hold[0]);
        push(mrc_pkg::KIND_RX, rx_hold[0], mrc_pkg::ST_OK, 1'b0);
        rx_hold[0] = rx_hold[1];
        rx_hold[1] = b;
      end else begin
        rx_hold[rx_seen - 1] = b;
        rx_seen++;
      end
      if (last) begin
        if (rx_seen < 3) begin
          st = mrc_pkg::ST_SHORT;
        end else begin
          st = ({rx_hold[1], rx_hold[0]} == rx_crc) ? mrc_pkg::ST_OK : mrc_pkg::ST_MISMATCH;
        end
        push(mrc_pkg::KIND_STATUS, 8'h00, st, 1'b1);
        rx_crc     = mrc_pkg::CRC_INIT;
        rx_seen    = 0;
        rx_hold[0] = 8'h00;
        rx_hold[1] = 8'h00;
      end
      return 1'b0;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_result(logic [1:0] k, logic [7:0] d, logic [1:0] s, logic e);
      mrc_pkg::item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d end %0d",
                                  k, d, s, e));
        return;
      end
      want = expected_q.pop_front();
      if (k !== want.kind) begin
        report_mismatch($sformatf("kind %0d, want %0d", k, want.kind));
      end
      if (d !== want.data) begin
        report_mismatch($sformatf("byte %02h, want %02h", d, want.data));
      end
      if (s !== want.status) begin
        report_mismatch($sformatf("status %0d, want %0d", s, want.status));
      end
      if (e !== want.eor) begin
        report_mismatch($sformatf("end_of_run %0d, want %0d", e, want.eor));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_write_en;
  logic [7:0] cfg_write_data;
  logic       in_valid;
  logic       in_ready;
  logic       in_mode;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_end_of_run;

  frame_scoreboard sb = new();

  // Handshake between stimulus and the receiver process for the long stall.
  bit hold_out;
  bit hold_on;

  int unsigned items_sent;
  stim_t       tx_q[$];
  stim_t       rx_q[$];

  modbus_rtu_frame_crc u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_end_of_run (out_end_of_run)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // One input transfer. Entered and left at a falling edge; valid stays up
  // after the transfer so that a back-to-back item keeps it high.
  task automatic send_item(logic mode, logic [7:0] b, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode      = mode;
    in_data_byte = b;
    in_last_byte = last;
    in_valid     = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (!sb.note_input(mode, b, last)) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  // Sender stops until every expected result is back and the pipe is empty.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_addr(logic [7:0] a);
    wait_idle();
    cfg_write_en   = 1'b1;
    cfg_write_data = a;
    sb.set_address(a);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  function automatic void build_tx(int unsigned len);
    stim_t s;
    for (int unsigned i = 0; i < len; i++) begin
      s.mode = 1'b0;
      s.data = 8'($urandom_range(0, 255));
      s.last = (i == len - 1);
      tx_q.push_back(s);
    end
  endfunction

  // Response ADU: address, payload, CRC low then high; optionally one bit
  // flipped somewhere so the check must fail.
  function automatic void build_rx(int unsigned plen, bit corrupt);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    stim_t       s;
    int unsigned pos;
    crc = mrc_pkg::CRC_INIT;
    for (int unsigned i = 0; i < plen + 1; i++) begin
      bytes.push_back(8'($urandom_range(0, 255)));
      crc = frame_scoreboard::fold(crc, bytes[i]);
    end
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    if (corrupt) begin
      pos        = $urandom_range(0, bytes.size() - 1);
      bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (bytes[i]) begin
      s.mode = 1'b1;
      s.data = bytes[i];
      s.last = (i == bytes.size() - 1);
      rx_q.push_back(s);
    end
  endfunction

  // Sends both queues, interleaving them at random in transfer order.
  task automatic send_queued();
    stim_t s;
    while (tx_q.size() != 0 || rx_q.size() != 0) begin
      if (rx_q.size() == 0 || (tx_q.size() != 0 && $urandom_range(0, 1) == 0)) begin
        s = tx_q.pop_front();
      end else begin
        s = rx_q.pop_front();
      end
      send_item(s.mode, s.data, s.last);
    end
  endtask

  function automatic logic [7:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 8'h00;
    end
    if (r < 18) begin
      return 8'hFF;
    end
    if (r < 24) begin
      return 8'h01;
    end
    return 8'($urandom_range(1, 254));
  endfunction

  // Receiver: random stalls with runs of steady ready, plus one long
  // hold-off on request, counted here in cycles.
  initial begin : out_side
    int unsigned r;
    out_ready = 1'b0;
    hold_on   = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_out) begin
        out_ready = 1'b0;
        hold_on   = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on  = 1'b0;
        hold_out = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_ready = 1'b1;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end else if (r < 93) begin
          out_ready = 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end else begin
          out_ready = 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  // Result transfers are checked at the edge where they happen.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_kind, out_byte, out_status, out_end_of_run);
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned frames;
    bit          flooded;
    bit          paused;
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = 8'h00;
    in_valid       = 1'b0;
    in_mode        = 1'b0;
    in_data_byte   = 8'h00;
    in_last_byte   = 1'b0;
    hold_out       = 1'b0;
    items_sent     = 0;
    frames         = 0;
    flooded        = 1'b0;
    paused         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Address still 0 after reset: the opening byte is dropped, and a
    // one-byte request only gives the address-not-defined status.
    send_item(1'b0, 8'h5A, 1'b0);
    send_item(1'b0, 8'hC3, 1'b1);

    // Top address, byte extremes, then a single-byte request.
    write_addr(8'hFF);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1);
    send_item(1'b0, 8'hA5, 1'b1);

    // Open a request, run a whole response through it, then change the
    // address mid-request: the request keeps the address it started with.
    send_item(1'b0, 8'h01, 1'b0);
    build_rx(1, 1'b0);
    send_queued();
    write_addr(8'h01);
    send_item(1'b0, 8'h80, 1'b1);

    // Too-short responses: one byte, then two bytes.
    send_item(1'b1, 8'hFF, 1'b1);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'h7E, 1'b1);

    // Address plus CRC with no payload, then a corrupted response.
    build_rx(0, 1'b0);
    send_queued();
    build_rx(2, 1'b1);
    send_queued();

    // Random part: mostly well-formed frames, some interleaved, some short,
    // some noise; the address moves every dozen frames.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 27) begin
        build_tx($urandom_range(1, 6));
      end else if (r < 30) begin
        build_tx($urandom_range(10, 24));
      end else if (r < 58) begin
        build_rx($urandom_range(0, 6), $urandom_range(0, 7) == 0);
      end else if (r < 75) begin
        build_tx($urandom_range(1, 6));
        build_rx($urandom_range(0, 6), $urandom_range(0, 7) == 0);
      end else if (r < 87) begin
        build_rx(0, 1'b0);
        // Cut to one or two bytes.
        repeat ($urandom_range(1, 2)) void'(rx_q.pop_back());
        rx_q[rx_q.size() - 1].last = 1'b1;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          tx_q.push_back(stim_t'({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1))}));
        end
      end
      send_queued();
      frames++;
      if (frames % 12 == 0) begin
        write_addr(pick_addr());
      end
      if (!flooded && items_sent > 200) begin
        // Hold the result side off while a long request keeps coming, so the
        // block backs up and drops in_ready.
        flooded  = 1'b1;
        in_valid = 1'b0;
        if (sb.slave_addr == 8'h00) begin
          write_addr(8'h5C);
        end
        hold_out = 1'b1;
        while (!hold_on) begin
          @(negedge clk);
        end
        build_tx(24);
        send_queued();
      end
      if (!paused && items_sent > 350) begin
        paused = 1'b1;
        wait_idle();
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
